/* src/wlwt_pkg.sv */
package wlwt_pkg;

  // Field and register widths
  localparam int NUM_SECTORS_DEF = 16;
  localparam int SECTOR_W        = 4;
  localparam int E_W             = 24;
  localparam int VISIT_W         = 32;
  localparam int STEP_W          = 24;
  localparam int T0_W            = 16;
  localparam int CNT_W           = 5;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 24;
  localparam int PT_W            = CNT_W + T0_W;       // peak * t0
  localparam int NUM_W           = STEP_W + PT_W;      // size * peak * t0
  localparam int DEN_W           = VISIT_W + 1;        // steps + peak * t0
  localparam int REM_W           = DEN_W + 1;
  localparam int DIV_CNT_W       = $clog2(NUM_W + 1);

  // Q8.16 limits and threshold
  localparam logic signed [E_W-1:0] E_MAX     = 24'sh7FFFFF;
  localparam logic signed [E_W-1:0] E_MIN     = 24'sh800000;
  localparam logic signed [E_W:0]   TENTH_Q16 = 25'sd6554;
  localparam logic [CNT_W-1:0]      CNT_SAT   = 5'd31;
  localparam logic [VISIT_W-1:0]    VISIT_SAT = 32'hFFFF_FFFF;

  // Reset values
  localparam logic [STEP_W-1:0]      STEP_SIZE_RST   = 24'd65536;
  localparam logic [T0_W-1:0]        CONST_STEPS_RST = 16'd100;
  localparam logic signed [E_W-1:0]  FLOOR_RST       = -24'sd2621440;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_SIZE   = 2'd0,
    REG_CONST_STEPS = 2'd1,
    REG_FLOOR_LEVEL = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PASS_MIN  = 2'd0,
    PASS_CNT  = 2'd1,
    PASS_MAX  = 2'd2,
    PASS_NORM = 2'd3
  } pass_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_SEC_WAIT,
    ST_MIN,
    ST_CNT,
    ST_MUL1,
    ST_MUL2,
    ST_DIV,
    ST_MAX,
    ST_NORM,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic  load;
    logic  cap_rd;
    logic  visit_wb;
    logic  pass_clr;
    logic  pass_run;
    pass_t pass_kind;
    logic  mul1;
    logic  div_start;
    logic  take_step;
    logic  step_inc;
    logic  finish;
  } wlwt_cmd_t;

  typedef struct packed {
    logic in_range;
    logic is_read;
    logic pass_done;
    logic div_done;
    logic out_full;
  } wlwt_stat_t;

endpackage

/* src/wlwt_ram.sv */
module wlwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/wlwt_ctrl.sv */
module wlwt_ctrl import wlwt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  wlwt_stat_t stat,
  output wlwt_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        // RAM reads of the named entry are issued here
        state_nxt = stat.in_range ? ST_SEC_WAIT : ST_DONE;
      end
      ST_SEC_WAIT: begin
        if (stat.is_read) begin
          cmd.cap_rd = 1'b1;
          state_nxt  = ST_DONE;
        end else begin
          cmd.visit_wb = 1'b1;
          cmd.pass_clr = 1'b1;
          state_nxt    = ST_MIN;
        end
      end
      ST_MIN: begin
        cmd.pass_run  = 1'b1;
        cmd.pass_kind = PASS_MIN;
        if (stat.pass_done) begin
          cmd.pass_clr = 1'b1;
          state_nxt    = ST_CNT;
        end
      end
      ST_CNT: begin
        cmd.pass_run  = 1'b1;
        cmd.pass_kind = PASS_CNT;
        if (stat.pass_done) begin
          cmd.pass_clr = 1'b1;
          state_nxt    = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (stat.div_done) begin
          cmd.take_step = 1'b1;
          cmd.pass_clr  = 1'b1;
          state_nxt     = ST_MAX;
        end
      end
      ST_MAX: begin
        cmd.pass_run  = 1'b1;
        cmd.pass_kind = PASS_MAX;
        if (stat.pass_done) begin
          cmd.pass_clr = 1'b1;
          state_nxt    = ST_NORM;
        end
      end
      ST_NORM: begin
        cmd.pass_run  = 1'b1;
        cmd.pass_kind = PASS_NORM;
        if (stat.pass_done) begin
          cmd.step_inc = 1'b1;
          state_nxt    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!stat.out_full) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* src/wlwt_dp.sv */
module wlwt_dp import wlwt_pkg::*; #(
  parameter int NUM_SECTORS = NUM_SECTORS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wlwt_cmd_t                   cmd,
  output wlwt_stat_t                  stat,
  input  logic                        in_operation,
  input  logic [SECTOR_W-1:0]         in_sector,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic signed [E_W-1:0]       out_energy_value,
  output logic [VISIT_W-1:0]          out_visit_count,
  output logic                        out_measured_flag,
  output logic [STEP_W-1:0]           out_step_applied,
  output logic [CNT_W-1:0]            out_sectors_above,
  output logic                        out_range_grew
);

  localparam int AW = $clog2(NUM_SECTORS);
  localparam int CW = $clog2(NUM_SECTORS + 1);
  localparam logic [CW-1:0] LAST = CW'(NUM_SECTORS);
  localparam int EW = E_W + 1;  // measured flag + energy

  // Configuration
  logic [STEP_W-1:0]     step_size_r;
  logic [T0_W-1:0]       t0_r;
  logic signed [E_W-1:0] floor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_size_r <= STEP_SIZE_RST;
      t0_r        <= CONST_STEPS_RST;
      floor_r     <= FLOOR_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_STEP_SIZE:   step_size_r <= cfg_wdata[STEP_W-1:0];
        REG_CONST_STEPS: t0_r        <= cfg_wdata[T0_W-1:0];
        REG_FLOOR_LEVEL: floor_r     <= $signed(cfg_wdata[E_W-1:0]);
        default: ;
      endcase
    end
  end

  // Item capture
  op_t                 op_r;
  logic [SECTOR_W-1:0] sec_r;
  logic [AW-1:0]       sec_idx;
  logic                in_range;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= op_t'(in_operation);
      sec_r <= in_sector;
    end
  end

  assign sec_idx  = AW'(sec_r);
  assign in_range = (32'(sec_r) < NUM_SECTORS);

  // Scan counter: read issued at cnt_r, data seen in the next cycle at pend_idx_r
  logic [CW-1:0] cnt_r;
  logic          pend_r;
  logic [AW-1:0] pend_idx_r;
  logic          pass_done;
  logic          issue;

  assign issue     = cmd.pass_run && (cnt_r != LAST);
  assign pass_done = (cnt_r == LAST) && !pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      pend_r <= 1'b0;
    end else if (cmd.pass_clr) begin
      cnt_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      if (issue) begin
        cnt_r <= cnt_r + 1'b1;
      end
      pend_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= cnt_r[AW-1:0];
  end

  // Energy RAM ({measured, energy}) and visit RAM
  logic [AW-1:0]      rd_idx;
  logic               e_we;
  logic [EW-1:0]      e_wdata;
  logic [EW-1:0]      e_rdata;
  logic               v_we;
  logic [VISIT_W-1:0] v_wdata;
  logic [VISIT_W-1:0] v_rdata;

  assign rd_idx = issue ? cnt_r[AW-1:0] : sec_idx;

  wlwt_ram #(.WIDTH(EW), .DEPTH(NUM_SECTORS)) u_e_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (pend_idx_r),
    .wdata (e_wdata),
    .raddr (rd_idx),
    .rdata (e_rdata)
  );

  wlwt_ram #(.WIDTH(VISIT_W), .DEPTH(NUM_SECTORS)) u_v_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (sec_idx),
    .wdata (v_wdata),
    .raddr (sec_idx),
    .rdata (v_rdata)
  );

  // Valid bits: an entry never written reads as zero
  logic [NUM_SECTORS-1:0] e_vld_r;
  logic [NUM_SECTORS-1:0] v_vld_r;
  logic                   e_vq_r;
  logic                   v_vq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= '0;
      v_vld_r <= '0;
    end else begin
      if (e_we) begin
        e_vld_r[pend_idx_r] <= 1'b1;
      end
      if (v_we) begin
        v_vld_r[sec_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    e_vq_r <= (32'(rd_idx) < NUM_SECTORS) ? e_vld_r[rd_idx] : 1'b0;
    v_vq_r <= in_range ? v_vld_r[sec_idx] : 1'b0;
  end

  // Entry arithmetic
  logic [EW-1:0]         ent_raw;
  logic signed [E_W-1:0] ent_e;
  logic                  ent_m;
  logic [STEP_W-1:0]     step_r;
  logic signed [E_W+1:0] upd_sum;
  logic signed [E_W-1:0] upd_e;
  logic                  at_sec;
  logic signed [E_W-1:0] cur_e;
  logic signed [E_W-1:0] mn_r;
  logic signed [E_W-1:0] mx_r;
  logic                  above;
  logic signed [E_W:0]   diff;
  logic signed [E_W:0]   floor_ext;
  logic signed [E_W:0]   clamp1;
  logic signed [E_W-1:0] norm_e;

  assign ent_raw = e_vq_r ? e_rdata : '0;
  assign ent_e   = $signed(ent_raw[E_W-1:0]);
  assign ent_m   = ent_raw[E_W];

  // named entry plus step, saturated at the top of Q8.16
  assign upd_sum = $signed({{2{ent_e[E_W-1]}}, ent_e}) + $signed({2'b00, step_r});
  assign upd_e   = (upd_sum > $signed({{2{E_MAX[E_W-1]}}, E_MAX})) ? E_MAX
                                                                   : upd_sum[E_W-1:0];
  assign at_sec  = (pend_idx_r == sec_idx) &&
                   ((cmd.pass_kind == PASS_MAX) || (cmd.pass_kind == PASS_NORM));
  assign cur_e   = at_sec ? upd_e : ent_e;

  assign above     = $signed({ent_e[E_W-1], ent_e}) >
                     ($signed({mn_r[E_W-1], mn_r}) + TENTH_Q16);
  assign diff      = $signed({cur_e[E_W-1], cur_e}) - $signed({mx_r[E_W-1], mx_r});
  assign floor_ext = $signed({floor_r[E_W-1], floor_r});
  assign clamp1    = (diff < floor_ext) ? floor_ext : diff;
  assign norm_e    = (clamp1 < $signed({E_MIN[E_W-1], E_MIN})) ? E_MIN
                                                              : clamp1[E_W-1:0];

  logic pass_data;
  assign pass_data = pend_r && cmd.pass_run;

  always_comb begin
    e_we    = 1'b0;
    e_wdata = {ent_m, ent_e};
    if (pass_data) begin
      case (cmd.pass_kind)
        PASS_CNT: begin
          e_we    = above;
          e_wdata = {1'b1, ent_e};
        end
        PASS_NORM: begin
          e_we    = 1'b1;
          e_wdata = {ent_m, norm_e};
        end
        default: ;
      endcase
    end
  end

  // Visit count, saturating
  logic [VISIT_W-1:0] v_cur;
  assign v_cur   = v_vq_r ? v_rdata : '0;
  assign v_we    = cmd.visit_wb;
  assign v_wdata = (v_cur == VISIT_SAT) ? v_cur : v_cur + 1'b1;

  // Scan accumulators and step control
  logic [CNT_W-1:0]   ns_r;
  logic [CNT_W-1:0]   peak_r;
  logic [CNT_W-1:0]   peak_new;
  logic [PT_W-1:0]    pt_r;
  logic [VISIT_W-1:0] steps_r;

  assign peak_new = (ns_r > peak_r) ? ns_r : peak_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ns_r <= CNT_W'(1);
    end else if (pass_data && cmd.pass_kind == PASS_CNT && above && ns_r != CNT_SAT) begin
      ns_r <= ns_r + 1'b1;
    end
    if (pass_data && cmd.pass_kind == PASS_MIN) begin
      if (pend_idx_r == '0 || ent_e < mn_r) begin
        mn_r <= ent_e;
      end
    end
    if (pass_data && cmd.pass_kind == PASS_MAX) begin
      if (pend_idx_r == '0 || cur_e > mx_r) begin
        mx_r <= cur_e;
      end
    end
    if (cmd.mul1) begin
      pt_r <= PT_W'(peak_new) * PT_W'(t0_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r  <= CNT_W'(1);
      steps_r <= VISIT_W'(1);
    end else begin
      if (cmd.mul1) begin
        peak_r <= peak_new;
      end
      if (cmd.step_inc && steps_r != VISIT_SAT) begin
        steps_r <= steps_r + 1'b1;
      end
    end
  end

  // Restoring divider, one quotient bit per cycle
  logic [NUM_W-1:0]     div_q_r;
  logic [REM_W-1:0]     div_rem_r;
  logic [DEN_W-1:0]     div_den_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [NUM_W-1:0]     prod;
  logic [REM_W-1:0]     div_sh;
  logic [REM_W:0]       div_trial;

  assign prod      = NUM_W'(step_size_r) * NUM_W'(pt_r);
  assign div_sh    = {div_rem_r[REM_W-2:0], div_q_r[NUM_W-1]};
  assign div_trial = {1'b0, div_sh} - {2'b00, div_den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.div_start) begin
      div_cnt_r <= DIV_CNT_W'(NUM_W);
    end else if (div_cnt_r != '0) begin
      div_cnt_r <= div_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_q_r   <= prod;
      div_rem_r <= '0;
      div_den_r <= DEN_W'(steps_r) + DEN_W'(pt_r);
    end else if (div_cnt_r != '0) begin
      if (!div_trial[REM_W]) begin
        div_rem_r <= div_trial[REM_W-1:0];
        div_q_r   <= {div_q_r[NUM_W-2:0], 1'b1};
      end else begin
        div_rem_r <= div_sh;
        div_q_r   <= {div_q_r[NUM_W-2:0], 1'b0};
      end
    end
    if (cmd.take_step) begin
      step_r <= (div_den_r == '0) ? '0 : div_q_r[STEP_W-1:0];
    end
  end

  // Result staging
  logic signed [E_W-1:0] res_e_r;
  logic [VISIT_W-1:0]    res_v_r;
  logic                  res_m_r;
  logic [STEP_W-1:0]     res_step_r;
  logic [CNT_W-1:0]      res_above_r;
  logic                  res_grew_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_step_r  <= '0;
      res_above_r <= '0;
      res_grew_r  <= 1'b0;
    end
    if (cmd.cap_rd) begin
      res_e_r <= ent_e;
      res_m_r <= ent_m;
      res_v_r <= v_cur;
    end
    if (cmd.visit_wb) begin
      res_v_r <= v_wdata;
    end
    if (cmd.mul1) begin
      res_above_r <= ns_r;
      res_grew_r  <= (ns_r > peak_r);
    end
    if (cmd.take_step) begin
      res_step_r <= (div_den_r == '0) ? '0 : div_q_r[STEP_W-1:0];
    end
    if (pass_data && cmd.pass_kind == PASS_NORM && pend_idx_r == sec_idx) begin
      res_e_r <= norm_e;
      res_m_r <= ent_m;
    end
  end

  // Output register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_energy_value  <= in_range ? res_e_r     : '0;
      out_visit_count   <= in_range ? res_v_r     : '0;
      out_measured_flag <= in_range ? res_m_r     : 1'b0;
      out_step_applied  <= in_range ? res_step_r  : '0;
      out_sectors_above <= in_range ? res_above_r : '0;
      out_range_grew    <= in_range ? res_grew_r  : 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  assign stat.in_range  = in_range;
  assign stat.is_read   = (op_r == OP_READ);
  assign stat.pass_done = pass_done;
  assign stat.div_done  = (div_cnt_r == '0);
  assign stat.out_full  = out_valid_r;

endmodule

/* src/wang_landau_weight_table_update.sv */
// Free-energy table for a sector-based flat-histogram sampler.
// Input channel (in_valid/in_ready): one item per transfer, in_operation
// selects update (0) or read (1) of sector in_sector. Result channel
// (out_valid/out_ready): exactly one result per item, in item order.
// An in-range update scans the table twice (minimum, above-threshold
// count), runs a 45-step restoring divider for the step, then scans twice
// more (maximum, normalize/clamp); each scan goes through a registered-read
// RAM. A read passes the start, wait and done states; an out-of-range
// sector skips the wait state and returns all-zero fields. in_ready rises
// again in the same cycle as out_valid.
// One item is in work at a time; in_ready is high only while idle.
// The result sits in an output register, so the next item is taken while
// a result waits; if the receiver stalls, the following result holds in
// the datapath until the output register frees up.
// Reset (rst_n, synchronous) restores the registers to their defaults and
// marks every table entry as zero through valid bits; no clearing pass.
// cfg_we writes the register named by cfg_index; write only while the block idles.
module wang_landau_weight_table_update import wlwt_pkg::*; #(
  parameter int NUM_SECTORS = NUM_SECTORS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_operation,
  input  logic [SECTOR_W-1:0]    in_sector,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [E_W-1:0]  out_energy_value,
  output logic [VISIT_W-1:0]     out_visit_count,
  output logic                   out_measured_flag,
  output logic [STEP_W-1:0]      out_step_applied,
  output logic [CNT_W-1:0]       out_sectors_above,
  output logic                   out_range_grew,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  // Controller sequences the scans and the divider; datapath owns all state but the controller's state register.
  wlwt_cmd_t  cmd;
  wlwt_stat_t stat;

  wlwt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  wlwt_dp #(.NUM_SECTORS(NUM_SECTORS)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_operation      (in_operation),
    .in_sector         (in_sector),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_energy_value  (out_energy_value),
    .out_visit_count   (out_visit_count),
    .out_measured_flag (out_measured_flag),
    .out_step_applied  (out_step_applied),
    .out_sectors_above (out_sectors_above),
    .out_range_grew    (out_range_grew)
  );

endmodule
